>>> rtl/load_current_regulator_top_assert.svh
// assertion macros used by the checker file
`ifndef LOAD_CURRENT_REGULATOR_TOP_ASSERT_SVH
`define LOAD_CURRENT_REGULATOR_TOP_ASSERT_SVH

// clocked property check, off while reset is held
`define LCR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be seen at a clock edge
`define LCR_ASSERT_NEVER(name, expr, msg) \
    `LCR_ASSERT(name, !(expr), msg)

`endif

>>> rtl/lcr_pkg.sv
package lcr_pkg;

    localparam int WINDOW_DEPTH = 3;
    localparam int SAMPLE_W     = 12;
    localparam int SUM_W        = $clog2(WINDOW_DEPTH * ((1 << SAMPLE_W) - 1) + 1);
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    localparam int CUR_W   = 9;
    localparam int VOLT_W  = 12;
    localparam int SET_W   = 9;
    localparam int PREV_W  = 8;
    localparam int TRIM_W  = 16;
    localparam int DAC_W   = 16;
    localparam int FAN_W   = 12;

    // ceil reciprocal of the fill count, exact for any window sum
    localparam int AVG_SHIFT = SUM_W + 3;
    localparam int RECIP_W   = AVG_SHIFT + 1;

    // shared multiplier
    localparam int A_W    = 20;
    localparam int B_W    = (RECIP_W > SAMPLE_W) ? RECIP_W : SAMPLE_W;
    localparam int PROD_W = 32;
    localparam int Y_W    = 20;
    localparam int PC_W   = 5;

    localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'(((1 << AVG_SHIFT) + 0) / 1);
    localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'(((1 << AVG_SHIFT) + 1) / 2);
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(((1 << AVG_SHIFT) + 2) / 3);
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(((1 << AVG_SHIFT) + 3) / 4);
    localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(((1 << AVG_SHIFT) + 4) / 5);
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(((1 << AVG_SHIFT) + 5) / 6);
    localparam logic [RECIP_W-1:0] RECIP_7 = RECIP_W'(((1 << AVG_SHIFT) + 6) / 7);
    localparam logic [RECIP_W-1:0] RECIP_8 = RECIP_W'(((1 << AVG_SHIFT) + 7) / 8);

    // current scale 206/2778 reduced to 103/1389
    localparam int CUR_MUL   = 103;
    localparam int CUR_DEN   = 1389;
    localparam int CUR_SHIFT = 19;
    localparam int CUR_RECIP = (1 << CUR_SHIFT) / CUR_DEN;

    // voltage scale 2178/4096
    localparam int VOLT_MUL   = 2178;
    localparam int VOLT_SHIFT = 12;

    // setpoint to dac step
    localparam int U_MUL          = 109;
    localparam int U_BIAS         = 4190;
    localparam int U_DEN          = 1000;
    localparam int U_SHIFT        = 16;
    localparam int U_RECIP        = (1 << U_SHIFT) / U_DEN;
    localparam int DAC_STEP_SHIFT = 12;
    localparam int DAC_DEN        = 330;
    localparam int DAC_SHIFT      = 18;
    localparam int DAC_RECIP      = (1 << DAC_SHIFT) / DAC_DEN;
    localparam int DAC_BASE       = 28672;

    // trim loop thresholds
    localparam int TRIM_CLEAR_BELOW = 5;
    localparam int STEADY_BAND      = 5;
    localparam int TARGET_BAND      = 3;

    // fan thresholds on current times voltage
    localparam int FAN_LOW_P  = 30000;
    localparam int FAN_HIGH_P = 80000;
    localparam int FAN_MID    = 1500;
    localparam int FAN_FULL   = 2500;

    localparam logic [1:0] CMD_CURRENT = 2'd0;
    localparam logic [1:0] CMD_VOLTAGE = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;

    typedef struct packed {
        logic [1:0]          command;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [CUR_W-1:0]  current_reading;
        logic [VOLT_W-1:0] voltage_reading;
        logic [DAC_W-1:0]  dac_word;
        logic [FAN_W-1:0]  fan_duty;
        logic              dac_send;
    } result_t;

    typedef enum logic [1:0] {SQ_NEXT, SQ_JUMP, SQ_DISPATCH, SQ_EMIT} seq_op_t;
    typedef enum logic [2:0] {A_SUM, A_PSH, A_Y, A_FC, A_SET} a_sel_t;
    typedef enum logic [1:0] {B_RECIP, B_CONST, B_FV} b_sel_t;
    typedef enum logic [3:0] {
        K_NONE, K_CUR_MUL, K_CUR_RECIP, K_CUR_DEN, K_VOLT_MUL,
        K_U_MUL, K_U_RECIP, K_U_DEN, K_DAC_RECIP, K_DAC_DEN
    } k_sel_t;
    typedef enum logic [2:0] {SH_NONE, SH_AVG, SH_CUR, SH_VOLT, SH_U, SH_DAC} sh_sel_t;
    typedef enum logic [1:0] {Q_HOLD, Q_LOAD, Q_FIX} q_op_t;
    typedef enum logic [1:0] {Y_HOLD, Y_LOAD, Y_BIAS, Y_UPSCALE} y_op_t;
    typedef enum logic [2:0] {
        WR_NONE, WR_PUSH, WR_CURRENT, WR_VOLTAGE, WR_FAN, WR_DAC
    } wr_op_t;
    typedef enum logic {CH_CUR, CH_VOLT} chan_t;

    // one microcode control word
    typedef struct packed {
        seq_op_t          seq;
        logic [PC_W-1:0]  target;
        a_sel_t           a_sel;
        b_sel_t           b_sel;
        k_sel_t           k_sel;
        sh_sel_t          sh_sel;
        logic             p_we;
        q_op_t            q_op;
        y_op_t            y_op;
        wr_op_t           wr_op;
        chan_t            chan;
    } ctrl_t;

    typedef struct packed {
        logic ready;
        logic accept;
        logic emit;
    } seq_evt_t;

    function automatic logic [RECIP_W-1:0] avg_recip(input logic [3:0] f);
        case (f)
            4'd1:    return RECIP_1;
            4'd2:    return RECIP_2;
            4'd3:    return RECIP_3;
            4'd4:    return RECIP_4;
            4'd5:    return RECIP_5;
            4'd6:    return RECIP_6;
            4'd7:    return RECIP_7;
            4'd8:    return RECIP_8;
            default: return '0;
        endcase
    endfunction

    function automatic logic [B_W-1:0] k_value(input k_sel_t k);
        case (k)
            K_CUR_MUL:   return B_W'(CUR_MUL);
            K_CUR_RECIP: return B_W'(CUR_RECIP);
            K_CUR_DEN:   return B_W'(CUR_DEN);
            K_VOLT_MUL:  return B_W'(VOLT_MUL);
            K_U_MUL:     return B_W'(U_MUL);
            K_U_RECIP:   return B_W'(U_RECIP);
            K_U_DEN:     return B_W'(U_DEN);
            K_DAC_RECIP: return B_W'(DAC_RECIP);
            K_DAC_DEN:   return B_W'(DAC_DEN);
            default:     return '0;
        endcase
    endfunction

endpackage

>>> rtl/lcr_window.sv
module lcr_window
    import lcr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [SAMPLE_W-1:0] sample,
    output logic [SUM_W-1:0]    sum,
    output logic [FILL_W-1:0]   fill
);

    logic [SAMPLE_W-1:0] win_reg [WINDOW_DEPTH];
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                full;
    logic [SAMPLE_W-1:0] oldest;

    assign full   = (fill_reg == FILL_W'(WINDOW_DEPTH));
    assign oldest = full ? win_reg[slot_reg] : '0;

    always_comb
    begin
        sum_next  = sum_reg - SUM_W'(oldest) + SUM_W'(sample);
        fill_next = full ? fill_reg : fill_reg + FILL_W'(1);
        slot_next = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else if (push)
        begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    // window entries are read only after being written
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            win_reg[slot_reg] <= sample;
        end
    end

    assign sum  = sum_reg;
    assign fill = fill_reg;

endmodule

>>> rtl/lcr_sequencer.sv
module lcr_sequencer
    import lcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [1:0] command,
    input  logic       out_free,
    output ctrl_t      ctrl,
    output seq_evt_t   evt
);

    localparam logic [PC_W-1:0] PC_IDLE = PC_W'(0);
    localparam logic [PC_W-1:0] PC_CUR  = PC_W'(1);
    localparam logic [PC_W-1:0] PC_VOLT = PC_W'(8);
    localparam logic [PC_W-1:0] PC_TICK = PC_W'(12);
    localparam logic [PC_W-1:0] PC_FIN  = PC_W'(23);

    logic [PC_W-1:0] pc_reg, pc_next;

    // seq, target, a, b, const, shift, p_we, q, y, write, channel
    function automatic ctrl_t ucode(input logic [PC_W-1:0] a);
        case (a)
            // idle: wait for a word, dispatch on command
            5'd0:  return '{SQ_DISPATCH, PC_IDLE, A_SUM, B_RECIP, K_NONE, SH_NONE, 1'b0,
                           Q_HOLD, Y_HOLD, WR_NONE, CH_CUR};
            // current sample
            5'd1:  return '{SQ_NEXT, PC_IDLE, A_SUM, B_RECIP, K_NONE, SH_NONE, 1'b0,
                           Q_HOLD, Y_HOLD, WR_PUSH, CH_CUR};
            5'd2:  return '{SQ_NEXT, PC_IDLE, A_SUM, B_RECIP, K_NONE, SH_NONE, 1'b1,
                           Q_HOLD, Y_HOLD, WR_NONE, CH_CUR};
            5'd3:  return '{SQ_NEXT, PC_IDLE, A_PSH, B_CONST, K_CUR_MUL, SH_AVG, 1'b1,
                           Q_HOLD, Y_HOLD, WR_NONE, CH_CUR};
            5'd4:  return '{SQ_NEXT, PC_IDLE, A_PSH, B_CONST, K_CUR_RECIP, SH_NONE, 1'b1,
                           Q_HOLD, Y_LOAD, WR_NONE, CH_CUR};
            5'd5:  return '{SQ_NEXT, PC_IDLE, A_PSH, B_CONST, K_CUR_DEN, SH_CUR, 1'b1,
                           Q_LOAD, Y_HOLD, WR_NONE, CH_CUR};
            5'd6:  return '{SQ_NEXT, PC_IDLE, A_SUM, B_RECIP, K_CUR_DEN, SH_NONE, 1'b0,
                           Q_FIX, Y_HOLD, WR_NONE, CH_CUR};
            5'd7:  return '{SQ_JUMP, PC_FIN, A_SUM, B_RECIP, K_NONE, SH_NONE, 1'b0,
                           Q_HOLD, Y_HOLD, WR_CURRENT, CH_CUR};
            // voltage sample
            5'd8:  return '{SQ_NEXT, PC_IDLE, A_SUM, B_RECIP, K_NONE, SH_NONE, 1'b0,
                           Q_HOLD, Y_HOLD, WR_PUSH, CH_VOLT};
            5'd9:  return '{SQ_NEXT, PC_IDLE, A_SUM, B_RECIP, K_NONE, SH_NONE, 1'b1,
                           Q_HOLD, Y_HOLD, WR_NONE, CH_VOLT};
            5'd10: return '{SQ_NEXT, PC_IDLE, A_PSH, B_CONST, K_VOLT_MUL, SH_AVG, 1'b1,
                           Q_HOLD, Y_HOLD, WR_NONE, CH_VOLT};
            5'd11: return '{SQ_JUMP, PC_FIN, A_SUM, B_RECIP, K_NONE, SH_VOLT, 1'b0,
                           Q_HOLD, Y_HOLD, WR_VOLTAGE, CH_VOLT};
            // tick: fan from power, then dac word
            5'd12: return '{SQ_NEXT, PC_IDLE, A_FC, B_FV, K_NONE, SH_NONE, 1'b1,
                           Q_HOLD, Y_HOLD, WR_NONE, CH_CUR};
            5'd13: return '{SQ_NEXT, PC_IDLE, A_SET, B_CONST, K_U_MUL, SH_NONE, 1'b1,
                           Q_HOLD, Y_HOLD, WR_FAN, CH_CUR};
            5'd14: return '{SQ_NEXT, PC_IDLE, A_SUM, B_RECIP, K_NONE, SH_NONE, 1'b0,
                           Q_HOLD, Y_BIAS, WR_NONE, CH_CUR};
            5'd15: return '{SQ_NEXT, PC_IDLE, A_Y, B_CONST, K_U_RECIP, SH_NONE, 1'b1,
                           Q_HOLD, Y_HOLD, WR_NONE, CH_CUR};
            5'd16: return '{SQ_NEXT, PC_IDLE, A_PSH, B_CONST, K_U_DEN, SH_U, 1'b1,
                           Q_LOAD, Y_HOLD, WR_NONE, CH_CUR};
            5'd17: return '{SQ_NEXT, PC_IDLE, A_SUM, B_RECIP, K_U_DEN, SH_NONE, 1'b0,
                           Q_FIX, Y_HOLD, WR_NONE, CH_CUR};
            5'd18: return '{SQ_NEXT, PC_IDLE, A_SUM, B_RECIP, K_NONE, SH_NONE, 1'b0,
                           Q_HOLD, Y_UPSCALE, WR_NONE, CH_CUR};
            5'd19: return '{SQ_NEXT, PC_IDLE, A_Y, B_CONST, K_DAC_RECIP, SH_NONE, 1'b1,
                           Q_HOLD, Y_HOLD, WR_NONE, CH_CUR};
            5'd20: return '{SQ_NEXT, PC_IDLE, A_PSH, B_CONST, K_DAC_DEN, SH_DAC, 1'b1,
                           Q_LOAD, Y_HOLD, WR_NONE, CH_CUR};
            5'd21: return '{SQ_NEXT, PC_IDLE, A_SUM, B_RECIP, K_DAC_DEN, SH_NONE, 1'b0,
                           Q_FIX, Y_HOLD, WR_NONE, CH_CUR};
            5'd22: return '{SQ_NEXT, PC_IDLE, A_SUM, B_RECIP, K_NONE, SH_NONE, 1'b0,
                           Q_HOLD, Y_HOLD, WR_DAC, CH_CUR};
            // hand the result to the output register
            5'd23: return '{SQ_EMIT, PC_IDLE, A_SUM, B_RECIP, K_NONE, SH_NONE, 1'b0,
                           Q_HOLD, Y_HOLD, WR_NONE, CH_CUR};
            default: return '{SQ_JUMP, PC_IDLE, A_SUM, B_RECIP, K_NONE, SH_NONE, 1'b0,
                             Q_HOLD, Y_HOLD, WR_NONE, CH_CUR};
        endcase
    endfunction

    function automatic logic [PC_W-1:0] dispatch(input logic [1:0] cmd);
        case (cmd)
            CMD_CURRENT: return PC_CUR;
            CMD_VOLTAGE: return PC_VOLT;
            CMD_TICK:    return PC_TICK;
            default:     return PC_FIN;
        endcase
    endfunction

    assign ctrl = ucode(pc_reg);

    // handshake outputs
    always_comb
    begin
        evt.ready  = (ctrl.seq == SQ_DISPATCH);
        evt.accept = evt.ready && item_valid;
        evt.emit   = (ctrl.seq == SQ_EMIT) && out_free;
    end

    // next step
    always_comb
    begin
        case (ctrl.seq)
            SQ_NEXT:     pc_next = pc_reg + PC_W'(1);
            SQ_JUMP:     pc_next = ctrl.target;
            SQ_DISPATCH: pc_next = item_valid ? dispatch(command) : pc_reg;
            SQ_EMIT:     pc_next = out_free ? ctrl.target : pc_reg;
            default:     pc_next = PC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> rtl/load_current_regulator_top.sv
// load current regulator: each input word carries a command and a 12-bit converter
// sample. a current or voltage sample enters that channel's moving-average window
// (up to WINDOW_DEPTH samples); the window sum is divided by the fill count, then
// scaled (current by 206/2778, voltage by 2178/4096, both truncating). a current
// sample also steps a trim offset toward the setpoint while the reading is steady
// and off target, and clears it when the reading drops below 5. a one-second tick
// yields the 16-bit dac word (setpoint step plus trim, wrapping) and a fan compare
// value of 0, 1500 or 2500 from current times voltage. every input word gives one
// result word with both filtered readings; dac_send marks tick results. writing
// set_current clears the trim; write it only while the block is idle. the words
// are processed one at a time by a microcoded sequencer that drives a single
// shared multiplier; divisions by constants run as reciprocal multiplies with a
// one-step correction. each command runs its own program, so the time per word
// depends on the command. the result sits in an output register, so a new word
// is taken while the last result waits.
module load_current_regulator_top
    import lcr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // input words
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item,
    // result words
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    // setpoint register
    input  logic             set_current_we,
    input  logic [SET_W-1:0] set_current
);

    ctrl_t    ctrl;
    seq_evt_t evt;
    logic     out_free;

    // datapath registers
    logic [SAMPLE_W-1:0] sample_reg;
    logic [PROD_W-1:0]   p_reg;
    logic [Y_W-1:0]      q_reg, q_next;
    logic [Y_W-1:0]      y_reg, y_next;

    // regulator state
    logic [SET_W-1:0]  set_reg;
    logic [TRIM_W-1:0] trim_reg;
    logic [CUR_W-1:0]  fc_reg;
    logic [VOLT_W-1:0] fv_reg;
    logic [PREV_W-1:0] prev_reg;

    // per-word tick outputs
    logic [DAC_W-1:0] dac_reg;
    logic [FAN_W-1:0] fan_reg;
    logic             send_reg;

    result_t result_reg;
    logic    result_valid_reg;

    // moving-average windows
    logic [SUM_W-1:0]  cur_sum, volt_sum;
    logic [FILL_W-1:0] cur_fill, volt_fill, fill_sel;

    // multiplier operands
    logic [PROD_W-1:0]  p_shift;
    logic [A_W-1:0]     a_op;
    logic [B_W-1:0]     b_op;
    logic [A_W+B_W-1:0] prod;
    logic [Y_W-1:0]     fix_diff;

    // current reading update
    logic [CUR_W-1:0]  r;
    logic [CUR_W-1:0]  diff_prev, diff_set;
    logic [TRIM_W-1:0] trim_base, trim_upd;

    logic [DAC_W-1:0] dac_calc;
    logic [FAN_W-1:0] fan_calc;

    assign out_free = !result_valid_reg || !result_stall;

    lcr_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .command    (item.command),
        .out_free   (out_free),
        .ctrl       (ctrl),
        .evt        (evt)
    );

    lcr_window u_cur_win (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   ((ctrl.wr_op == WR_PUSH) && (ctrl.chan == CH_CUR)),
        .sample (sample_reg),
        .sum    (cur_sum),
        .fill   (cur_fill)
    );

    lcr_window u_volt_win (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   ((ctrl.wr_op == WR_PUSH) && (ctrl.chan == CH_VOLT)),
        .sample (sample_reg),
        .sum    (volt_sum),
        .fill   (volt_fill)
    );

    assign fill_sel = (ctrl.chan == CH_CUR) ? cur_fill : volt_fill;

    // fixed shifts of the product register
    always_comb
    begin
        case (ctrl.sh_sel)
            SH_NONE: p_shift = p_reg;
            SH_AVG:  p_shift = p_reg >> AVG_SHIFT;
            SH_CUR:  p_shift = p_reg >> CUR_SHIFT;
            SH_VOLT: p_shift = p_reg >> VOLT_SHIFT;
            SH_U:    p_shift = p_reg >> U_SHIFT;
            SH_DAC:  p_shift = p_reg >> DAC_SHIFT;
            default: p_shift = p_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.a_sel)
            A_SUM:   a_op = (ctrl.chan == CH_CUR) ? A_W'(cur_sum) : A_W'(volt_sum);
            A_PSH:   a_op = p_shift[A_W-1:0];
            A_Y:     a_op = A_W'(y_reg);
            A_FC:    a_op = A_W'(fc_reg);
            A_SET:   a_op = A_W'(set_reg);
            default: a_op = '0;
        endcase
    end

    always_comb
    begin
        case (ctrl.b_sel)
            B_RECIP: b_op = B_W'(avg_recip(4'(fill_sel)));
            B_CONST: b_op = k_value(ctrl.k_sel);
            B_FV:    b_op = B_W'(fv_reg);
            default: b_op = '0;
        endcase
    end

    assign prod = a_op * b_op;

    // quotient estimate is low by at most one: y - q*d tells which
    assign fix_diff = y_reg - p_reg[Y_W-1:0];

    always_comb
    begin
        case (ctrl.q_op)
            Q_HOLD:  q_next = q_reg;
            Q_LOAD:  q_next = p_shift[Y_W-1:0];
            Q_FIX:   q_next = (fix_diff >= Y_W'(k_value(ctrl.k_sel))) ?
                              q_reg + Y_W'(1) : q_reg;
            default: q_next = q_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.y_op)
            Y_HOLD:    y_next = y_reg;
            Y_LOAD:    y_next = p_reg[Y_W-1:0];
            Y_BIAS:    y_next = p_reg[Y_W-1:0] + Y_W'(U_BIAS);
            Y_UPSCALE: y_next = (q_reg + Y_W'(1)) << DAC_STEP_SHIFT;
            default:   y_next = y_reg;
        endcase
    end

    // trim loop on a new current reading
    always_comb
    begin
        r         = q_reg[CUR_W-1:0];
        diff_prev = (r > CUR_W'(prev_reg)) ? r - CUR_W'(prev_reg) : CUR_W'(prev_reg) - r;
        diff_set  = (r > set_reg) ? r - set_reg : set_reg - r;
        trim_base = (r < CUR_W'(TRIM_CLEAR_BELOW)) ? '0 : trim_reg;
        if ((diff_prev < CUR_W'(STEADY_BAND)) && (diff_set >= CUR_W'(TARGET_BAND)))
        begin
            trim_upd = (set_reg > r) ? trim_base + TRIM_W'(1) : trim_base - TRIM_W'(1);
        end
        else
        begin
            trim_upd = trim_base;
        end
    end

    // dac word and fan duty for a tick
    always_comb
    begin
        if (set_reg == '0)
        begin
            dac_calc = DAC_W'(DAC_BASE);
        end
        else
        begin
            dac_calc = DAC_W'(DAC_BASE) + q_reg[DAC_W-1:0] + trim_reg;
        end
        if (p_reg < PROD_W'(FAN_LOW_P))
        begin
            fan_calc = '0;
        end
        else if (p_reg > PROD_W'(FAN_HIGH_P))
        begin
            fan_calc = FAN_W'(FAN_FULL);
        end
        else
        begin
            fan_calc = FAN_W'(FAN_MID);
        end
    end

    // regulator state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reg          <= '0;
            trim_reg         <= '0;
            fc_reg           <= '0;
            fv_reg           <= '0;
            prev_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (set_current_we)
            begin
                set_reg  <= set_current;
                trim_reg <= '0;
            end
            else if (ctrl.wr_op == WR_CURRENT)
            begin
                trim_reg <= trim_upd;
            end
            if (ctrl.wr_op == WR_CURRENT)
            begin
                fc_reg   <= r;
                prev_reg <= r[PREV_W-1:0];
            end
            if (ctrl.wr_op == WR_VOLTAGE)
            begin
                fv_reg <= p_shift[VOLT_W-1:0];
            end
            if (evt.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // datapath and result payload
    always_ff @(posedge clk)
    begin
        if (evt.accept)
        begin
            sample_reg <= item.sample;
        end
        if (ctrl.p_we)
        begin
            p_reg <= prod[PROD_W-1:0];
        end
        q_reg <= q_next;
        y_reg <= y_next;
        if (evt.accept)
        begin
            dac_reg  <= '0;
            fan_reg  <= '0;
            send_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.wr_op == WR_FAN)
            begin
                fan_reg <= fan_calc;
            end
            if (ctrl.wr_op == WR_DAC)
            begin
                dac_reg  <= dac_calc;
                send_reg <= 1'b1;
            end
        end
        if (evt.emit)
        begin
            result_reg.current_reading <= fc_reg;
            result_reg.voltage_reading <= fv_reg;
            result_reg.dac_word        <= dac_reg;
            result_reg.fan_duty        <= fan_reg;
            result_reg.dac_send        <= send_reg;
        end
    end

    assign item_stall   = !evt.ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/lcr_checker.sv
`include "load_current_regulator_top_assert.svh"

module lcr_checker
    import lcr_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // a stalled result word holds
    `LCR_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result word changed")

    // one word in work at a time: the block is busy right after taking a word
    `LCR_ASSERT(a_busy_after_accept, item_valid && !item_stall |=> item_stall, "word accepted while the previous one is in work")

    // non-tick results carry no dac word or fan duty
    `LCR_ASSERT_NEVER(a_quiet_non_tick, result_valid && !result.dac_send && (result.dac_word != '0 || result.fan_duty != '0), "dac or fan value on a non-tick result")

    // fan duty takes one of three levels
    `LCR_ASSERT(a_fan_levels, result_valid && result.dac_send |-> result.fan_duty == '0 || result.fan_duty == FAN_W'(FAN_MID) || result.fan_duty == FAN_W'(FAN_FULL), "fan duty off its levels")

endmodule

bind load_current_regulator_top lcr_checker u_lcr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

>>> test/tb_load_current_regulator_top.sv
module tb_load_current_regulator_top;
    import lcr_pkg::*;

    // scaling and threshold numbers of the regulator
    localparam int CUR_NUM    = 206;
    localparam int CUR_DIV    = 2778;
    localparam int VOLT_NUM   = 2178;
    localparam int VOLT_DIV   = 4096;
    localparam int SP_MUL     = 109;
    localparam int SP_BIAS    = 4190;
    localparam int SP_DIV     = 1000;
    localparam int DAC_ZERO   = 28672;
    localparam int STEP_NUM   = 4096;
    localparam int STEP_DIV   = 330;
    localparam int P_LOW      = 30000;
    localparam int P_HIGH     = 80000;
    localparam int DUTY_MID   = 1500;
    localparam int DUTY_FULL  = 2500;
    localparam int TRIM_FLOOR = 5;
    localparam int STEADY_LIM = 5;
    localparam int TARGET_LIM = 3;

    // command code the block does not use
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int MAX_SAMPLE  = (1 << SAMPLE_W) - 1;
    localparam int SETTLE_CYC  = 16;
    localparam int HOLD_CYC    = 200;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_CAP   = 50;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    item_t             item = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result;
    logic              set_current_we = 1'b0;
    logic [SET_W-1:0]  set_current = '0;

    load_current_regulator_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .set_current_we (set_current_we),
        .set_current    (set_current)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // predicted state of the regulator
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] win_mem [2][WINDOW_DEPTH];
    int unsigned         win_sum  [2] = '{0, 0};
    int unsigned         win_fill [2] = '{0, 0};
    int unsigned         win_slot [2] = '{0, 0};
    logic [CUR_W-1:0]    filt_cur  = '0;
    logic [VOLT_W-1:0]   filt_volt = '0;
    logic [PREV_W-1:0]   prev_cur  = '0;
    logic [TRIM_W-1:0]   trim      = '0;
    logic [SET_W-1:0]    setpoint  = '0;

    // results owed by the block, oldest first
    result_t results_due [$];
    result_t want_res;

    // run bookkeeping
    int unsigned cycle_count = 0;
    int          err_count   = 0;
    int          n_checked   = 0;
    int          n_by_cmd [4] = '{0, 0, 0, 0};
    int          n_writes    = 0;
    int          trim_steps  = 0;
    int          longest_hold = 0;

    // idling control shared by both sides
    bit idle_on    = 1'b1;
    int stall_left = 0;
    int hold_len   = 0;
    int hold_left  = 0;

    // moving average: add a sample to the channel window, return sum / fill
    function automatic int unsigned push_avg(input chan_t ch, input logic [SAMPLE_W-1:0] x);
        int unsigned s;
        s = win_slot[ch];
        if (win_fill[ch] < WINDOW_DEPTH)
            win_fill[ch]++;
        else
            win_sum[ch] -= win_mem[ch][s];
        win_mem[ch][s] = x;
        win_sum[ch] += x;
        win_slot[ch] = (s + 1 >= WINDOW_DEPTH) ? 0 : s + 1;
        return win_sum[ch] / win_fill[ch];
    endfunction

    function automatic int unsigned abs_diff(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    // advance the predicted state by one word and build the result it owes
    function automatic result_t calc_result(input logic [1:0] cmd,
                                            input logic [SAMPLE_W-1:0] x);
        result_t     r;
        int unsigned rd, u, p, dac;
        r = '0;
        case (cmd)
            CMD_CURRENT:
            begin
                rd = push_avg(CH_CUR, x) * CUR_NUM / CUR_DIV;
                filt_cur = CUR_W'(rd);
                // a reading near zero drops the trim
                if (rd < TRIM_FLOOR)
                    trim = '0;
                // steady but off target: one step toward the setpoint
                if (abs_diff(rd, prev_cur) < STEADY_LIM && abs_diff(rd, setpoint) >= TARGET_LIM)
                begin
                    trim = (setpoint > rd) ? trim + 1'b1 : trim - 1'b1;
                    trim_steps++;
                end
                // only the low byte is remembered
                prev_cur = PREV_W'(rd);
            end
            CMD_VOLTAGE:
            begin
                filt_volt = VOLT_W'(push_avg(CH_VOLT, x) * VOLT_NUM / VOLT_DIV);
            end
            CMD_TICK:
            begin
                u = (setpoint * SP_MUL + SP_BIAS) / SP_DIV;
                p = filt_cur * filt_volt;
                if (setpoint != 0)
                    dac = DAC_ZERO + (u + 1) * STEP_NUM / STEP_DIV + trim;
                else
                    dac = DAC_ZERO;
                r.dac_word = DAC_W'(dac);
                if (p < P_LOW)
                    r.fan_duty = '0;
                else if (p > P_HIGH)
                    r.fan_duty = FAN_W'(DUTY_FULL);
                else
                    r.fan_duty = FAN_W'(DUTY_MID);
                r.dac_send = 1'b1;
            end
            default:
            begin
                // unused command leaves all state alone
            end
        endcase
        r.current_reading = filt_cur;
        r.voltage_reading = filt_volt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      n_checked, name, got, want));
    endtask

    // sample at the rising edge; also draws the receiver wait for the next word
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            n_checked++;
            stall_left = idle_on ? $urandom_range(0, 4) : 0;
            if (results_due.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          n_checked));
            else
            begin
                want_res = results_due.pop_front();
                check_field("current_reading", result.current_reading,
                            want_res.current_reading);
                check_field("voltage_reading", result.voltage_reading,
                            want_res.voltage_reading);
                check_field("dac_word", result.dac_word, want_res.dac_word);
                check_field("fan_duty", result.fan_duty, want_res.fan_duty);
                check_field("dac_send", result.dac_send, want_res.dac_send);
            end
        end
    end

    // receiver: random wait after each word, plus the long hold when asked
    always @(negedge clk)
    begin
        if (hold_len > 0)
        begin
            hold_left = hold_len;
            if (hold_len > longest_hold)
                longest_hold = hold_len;
            hold_len = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // watchdog on total run length
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, results_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // sender side; every task starts and ends just after a falling edge
    // ------------------------------------------------------------------
    // offer one word after a random gap and hold it until taken
    task automatic send_word(input logic [1:0] cmd, input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= '{command: cmd, sample: s};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        results_due.push_back(calc_result(cmd, s));
        n_by_cmd[cmd]++;
        @(negedge clk);
    endtask

    // stop offering, let every owed result drain, then a short settle
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // setpoint write, only with the block idle; it also clears the trim
    task automatic write_setpoint(input logic [SET_W-1:0] v);
        wait_idle();
        set_current_we <= 1'b1;
        set_current <= v;
        @(negedge clk);
        set_current_we <= 1'b0;
        setpoint = v;
        trim = '0;
        n_writes++;
        @(negedge clk);
    endtask

    // sample near a base value, clamped to the converter range
    function automatic logic [SAMPLE_W-1:0] near_sample(input int base);
        int v;
        v = base + int'($urandom_range(0, 30)) - 15;
        if (v < 0)
            v = 0;
        if (v > MAX_SAMPLE)
            v = MAX_SAMPLE;
        return SAMPLE_W'(v);
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // fresh state: tick with zero setpoint, unused command, zero current
    task automatic test_after_reset();
        send_word(CMD_TICK, '0);
        send_word(CMD_UNUSED, SAMPLE_W'(MAX_SAMPLE));
        send_word(CMD_CURRENT, '0);
    endtask

    // full scale on both channels, then back to zero
    task automatic test_sample_extremes();
        write_setpoint(SET_W'(299));
        // full scale reading wraps the remembered byte, so no trim step
        repeat (3) send_word(CMD_CURRENT, SAMPLE_W'(MAX_SAMPLE));
        send_word(CMD_VOLTAGE, SAMPLE_W'(MAX_SAMPLE));
        send_word(CMD_TICK, '0);
        send_word(CMD_CURRENT, '0);
        send_word(CMD_VOLTAGE, '0);
    endtask

    // trim steps down through zero, then up, then clears on a low reading
    task automatic test_trim_loop();
        write_setpoint(SET_W'(1));
        // reading about 100 held steady above a setpoint of 1
        repeat (5) send_word(CMD_CURRENT, SAMPLE_W'(1349));
        // voltage near 500 puts the power in the middle fan band
        repeat (3) send_word(CMD_VOLTAGE, SAMPLE_W'(940));
        send_word(CMD_TICK, '0);
        write_setpoint(SET_W'(299));
        repeat (4) send_word(CMD_CURRENT, SAMPLE_W'(1349));
        send_word(CMD_TICK, '0);
        repeat (3) send_word(CMD_CURRENT, '0);
        send_word(CMD_TICK, '0);
    endtask

    // mostly steady runs with jitter, some noise and unused commands
    task automatic test_random_mix();
        int base_cur, base_volt, run_left, pick;
        logic [SET_W-1:0] sp;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       sp = SET_W'(299);
                1:       sp = '0;
                2:       sp = SET_W'(511);
                3:       sp = SET_W'($urandom_range(300, 511));
                default: sp = SET_W'($urandom_range(0, 299));
            endcase
            write_setpoint(sp);
            // one phase runs with no idling on either side
            idle_on = (ph != 4);
            run_left = 0;
            base_cur = 0;
            base_volt = 0;
            for (int k = 0; k < 240; k++)
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(10, 40);
                    pick = $urandom_range(0, 9);
                    if (pick < 5)
                        // readings around the setpoint drive the trim both ways
                        base_cur = sp * 1349 / 100 + int'($urandom_range(0, 200)) - 100;
                    else if (pick < 8)
                        base_cur = $urandom_range(0, MAX_SAMPLE);
                    else
                        // low readings, some of them low enough to clear the trim
                        base_cur = $urandom_range(0, 80);
                    base_volt = $urandom_range(0, MAX_SAMPLE);
                end
                run_left--;
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    send_word(CMD_UNUSED, SAMPLE_W'($urandom));
                else if (pick < 10)
                    send_word(2'($urandom_range(0, 2)), SAMPLE_W'($urandom));
                else if (pick < 50)
                    send_word(CMD_CURRENT, near_sample(base_cur));
                else if (pick < 80)
                    send_word(CMD_VOLTAGE, near_sample(base_volt));
                else
                    send_word(CMD_TICK, SAMPLE_W'($urandom));
            end
        end
        idle_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        wait_idle();
        idle_on = 1'b0;
        hold_len = HOLD_CYC;
        repeat (40)
            send_word(2'($urandom_range(0, 2)), SAMPLE_W'($urandom));
        wait_idle();
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_after_reset();
        test_sample_extremes();
        test_trim_loop();
        test_backpressure();
        test_random_mix();

        wait_idle();
        repeat (SETTLE_CYC) @(posedge clk);

        $display("covered %0d words: %0d current, %0d voltage, %0d ticks, %0d unused",
                 n_by_cmd[0] + n_by_cmd[1] + n_by_cmd[2] + n_by_cmd[3],
                 n_by_cmd[CMD_CURRENT], n_by_cmd[CMD_VOLTAGE], n_by_cmd[CMD_TICK],
                 n_by_cmd[CMD_UNUSED]);
        $display("%0d results checked, %0d setpoint writes, %0d trim steps, hold of %0d cycles",
                 n_checked, n_writes, trim_steps, longest_hold);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
